FILE: src/per_key_request_count_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-key request count table
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PER_KEY_REQUEST_COUNT_TABLE_UNIT_DEFINES_SVH
`define PER_KEY_REQUEST_COUNT_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PKRCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PKRCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pkrct_pkg.sv
// ----------------------------------------------------------------------------
// Per-key request count table package
// Sizes, operation codes, controller commands and the count clip function.
// ----------------------------------------------------------------------------
package pkrct_pkg;

  localparam int TableDepth = 16;
  localparam int CountWidth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int KeyW       = 32;
  localparam int OutW       = 16;
  localparam int WideW      = (CountWidth > OutW) ? CountWidth : OutW;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_REMOVE  = 2'd3
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming item
    logic lookup;  // compare the key against all entries
    logic commit;  // update the table and load the result register
  } cmd_t;

  // Clip a stored count to the width of the result field.
  function automatic logic [OutW-1:0] clip_count(input logic [CountWidth-1:0] c);
    logic [WideW-1:0] ext;
    ext = WideW'(c);
    if (ext > WideW'({OutW{1'b1}})) begin
      return {OutW{1'b1}};
    end
    return ext[OutW-1:0];
  endfunction

endpackage

FILE: src/pkrct_if.sv
// ----------------------------------------------------------------------------
// Per-key request count table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pkrct_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [pkrct_pkg::KeyW-1:0] client_addr;

  modport source (output valid, output req_type, output client_addr, input ready);
  modport sink   (input valid, input req_type, input client_addr, output ready);
endinterface

interface pkrct_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [pkrct_pkg::OutW-1:0] request_count;
  logic                       hit;
  logic                       table_full;

  modport source (output valid, output request_count, output hit, output table_full,
                  input ready);
  modport sink   (input valid, input request_count, input hit, input table_full,
                  output ready);
endinterface

FILE: src/pkrct_ctrl.sv
// ----------------------------------------------------------------------------
// Per-key request count table controller
// Sequences capture, lookup and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module pkrct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output pkrct_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   drain_ok;
  logic   load;
  logic   commit;

  // The result register can take a new item when empty or being emptied.
  assign drain_ok   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_COMMIT) && drain_ok);
  assign load       = in_valid_i && in_ready_o;
  assign commit     = (state_q == ST_COMMIT) && drain_ok;

  assign cmd_o.load   = load;
  assign cmd_o.lookup = (state_q == ST_LOOKUP);
  assign cmd_o.commit = commit;
  assign out_valid_o  = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_d = load ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/pkrct_dp.sv
// ----------------------------------------------------------------------------
// Per-key request count table datapath
// Entry storage, parallel key compare, count update and result register.
// ----------------------------------------------------------------------------
module pkrct_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pkrct_pkg::cmd_t                   cmd_i,
  input  logic [1:0]                        req_type_i,
  input  logic [pkrct_pkg::KeyW-1:0]        client_addr_i,
  output logic [pkrct_pkg::OutW-1:0]        request_count_o,
  output logic                              hit_o,
  output logic                              table_full_o
);

  localparam logic [pkrct_pkg::CountWidth-1:0] CountMax = '1;
  localparam logic [pkrct_pkg::CountWidth-1:0] CountOne = pkrct_pkg::CountWidth'(1);

  // Table storage: valid bits are reset, keys and counts are written before use.
  logic [pkrct_pkg::TableDepth-1:0] valid_q, valid_d;
  logic [pkrct_pkg::KeyW-1:0]       key_q [pkrct_pkg::TableDepth];
  logic [pkrct_pkg::CountWidth-1:0] cnt_q [pkrct_pkg::TableDepth];

  // Captured item.
  pkrct_pkg::op_e             op_q;
  logic [pkrct_pkg::KeyW-1:0] req_key_q;

  // Lookup results.
  logic                       hit_q, hit_d;
  logic                       full_q, full_d;
  logic [pkrct_pkg::IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [pkrct_pkg::IdxW-1:0] free_idx_q, free_idx_d;

  // Commit-phase signals.
  logic [pkrct_pkg::CountWidth-1:0] cnt_rd;
  logic [pkrct_pkg::IdxW-1:0]       wr_idx;
  logic                             wr_key_en;
  logic                             wr_cnt_en;
  logic [pkrct_pkg::CountWidth-1:0] wr_cnt;
  logic                             set_valid;
  logic                             clr_valid;
  logic [pkrct_pkg::OutW-1:0]       res_count;
  logic                             res_full;

  // Result register.
  logic [pkrct_pkg::OutW-1:0] out_count_q;
  logic                       out_hit_q;
  logic                       out_full_q;

  // Parallel compare; at most one valid entry can hold the key.
  always_comb begin
    hit_d      = 1'b0;
    hit_idx_d  = '0;
    free_idx_d = '0;
    full_d     = &valid_q;
    for (int i = 0; i < pkrct_pkg::TableDepth; i++) begin
      if (valid_q[i] && (key_q[i] == req_key_q)) begin
        hit_d     = 1'b1;
        hit_idx_d = hit_idx_d | pkrct_pkg::IdxW'(i);
      end
    end
    // Scan downwards so the lowest free index wins.
    for (int i = pkrct_pkg::TableDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx_d = pkrct_pkg::IdxW'(i);
    end
  end

  assign cnt_rd = cnt_q[hit_idx_q];
  assign wr_idx = hit_q ? hit_idx_q : free_idx_q;

  always_comb begin
    wr_key_en = 1'b0;
    wr_cnt_en = 1'b0;
    wr_cnt    = cnt_rd;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    res_count = '0;
    res_full  = 1'b0;
    unique case (op_q)
      pkrct_pkg::OP_ENQUEUE: begin
        if (hit_q) begin
          wr_cnt_en = 1'b1;
          wr_cnt    = (cnt_rd == CountMax) ? cnt_rd : cnt_rd + CountOne;
          res_count = pkrct_pkg::clip_count(wr_cnt);
        end else if (!full_q) begin
          wr_key_en = 1'b1;
          wr_cnt_en = 1'b1;
          wr_cnt    = CountOne;
          set_valid = 1'b1;
          res_count = pkrct_pkg::OutW'(1);
        end else begin
          res_full = 1'b1;
        end
      end
      pkrct_pkg::OP_DEQUEUE: begin
        if (hit_q) begin
          if (cnt_rd <= CountOne) begin
            clr_valid = 1'b1;
          end else begin
            wr_cnt_en = 1'b1;
            wr_cnt    = cnt_rd - CountOne;
            res_count = pkrct_pkg::clip_count(wr_cnt);
          end
        end
      end
      pkrct_pkg::OP_QUERY: begin
        if (hit_q) res_count = pkrct_pkg::clip_count(cnt_rd);
      end
      pkrct_pkg::OP_REMOVE: begin
        if (hit_q) clr_valid = 1'b1;
      end
      default: begin
        res_count = '0;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.commit && set_valid) valid_d[wr_idx] = 1'b1;
    if (cmd_i.commit && clr_valid) valid_d[wr_idx] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= pkrct_pkg::op_e'(req_type_i);
      req_key_q <= client_addr_i;
    end
    if (cmd_i.lookup) begin
      hit_q      <= hit_d;
      full_q     <= full_d;
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
    end
    if (cmd_i.commit) begin
      if (wr_key_en) key_q[wr_idx] <= req_key_q;
      if (wr_cnt_en) cnt_q[wr_idx] <= wr_cnt;
      out_count_q <= res_count;
      out_hit_q   <= hit_q;
      out_full_q  <= res_full;
    end
  end

  assign request_count_o = out_count_q;
  assign hit_o           = out_hit_q;
  assign table_full_o    = out_full_q;

endmodule

FILE: src/per_key_request_count_table_unit.sv
// An accepted item is captured, its lookup results are registered, and its result
// is loaded into the output register unless the commit stalls. Each item has a
// lookup phase (all keys compared at once) and a commit phase (count update and
// write-back) that may accept the next item and stalls while a result waits.
// Reset (asynchronous, active low) empties the table and the result register at once.
// ----------------------------------------------------------------------------
// Per-key request count table
// Content-addressed table of client addresses, each with an outstanding request
// count, supporting enqueue, dequeue, query and remove.
// ----------------------------------------------------------------------------
`include "per_key_request_count_table_unit_defines.svh"

module per_key_request_count_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  pkrct_req_if.sink   req_i,
  pkrct_rsp_if.source rsp_o
);

  // The controller steps each item through three phases. At the accepting edge
  // the operation and key are captured. In the lookup cycle the key is compared
  // with every valid entry in parallel and the matching index and the lowest
  // free index are registered. In the commit cycle the matched count is read,
  // incremented, decremented or left alone, written back together with any
  // change of the valid bit, and the result is loaded into the output register.
  // The commit cycle may also accept the next item, so a new lookup always
  // sees the table as left by the item before it.

  pkrct_pkg::cmd_t cmd;

  pkrct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  pkrct_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .req_type_i      (req_i.req_type),
    .client_addr_i   (req_i.client_addr),
    .request_count_o (rsp_o.request_count),
    .hit_o           (rsp_o.hit),
    .table_full_o    (rsp_o.table_full)
  );

  // Every accepted item is compared in the cycle after it is taken.
  `PKRCT_ASSERT_NEXT(a_load_then_lookup, cmd.load, cmd.lookup, "accepted item was not looked up")
  // A commit always leaves a result waiting at the output.
  `PKRCT_ASSERT_NEXT(a_commit_then_valid, cmd.commit, rsp_o.valid, "commit produced no result")
  // A commit never overwrites a result that has not been taken.
  `PKRCT_ASSERT_SAME(a_no_overwrite, cmd.commit, !rsp_o.valid || rsp_o.ready, "result overwritten")

endmodule

FILE: sim/tb_per_key_request_count_table_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the per-key request count table
// Drives enqueue, dequeue, query and remove items through the request channel,
// predicts every response from a local copy of the table, and checks each
// response field by field under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_per_key_request_count_table_unit;

  // Cycles without any accepted item, on either channel, before the run is abandoned.
  // The longest deliberate quiet stretch is the long receiver hold-off below.
  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 300;
  localparam int KeyPoolSize   = 24;
  localparam int ClimbSteps    = 30;
  localparam logic [pkrct_pkg::CountWidth-1:0] CountMax = {pkrct_pkg::CountWidth{1'b1}};

  // One expected response, in the order the block is to return them.
  typedef struct packed {
    logic [pkrct_pkg::OutW-1:0] count;
    logic                       hit;
    logic                       full;
  } count_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pkrct_req_if req_if ();
  pkrct_rsp_if rsp_if ();

  per_key_request_count_table_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the table, updated as each item is accepted.
  logic                             slot_busy  [pkrct_pkg::TableDepth];
  logic [pkrct_pkg::KeyW-1:0]       slot_key   [pkrct_pkg::TableDepth];
  logic [pkrct_pkg::CountWidth-1:0] slot_count [pkrct_pkg::TableDepth];

  count_result_t              expected_results[$];
  count_result_t              oldest_result;
  logic [pkrct_pkg::KeyW-1:0] key_pool[KeyPoolSize];

  int   error_count    = 0;
  int   quiet_cycles   = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;
  // The test flips hold_req to ask for a hold-off; the receiver answers with hold_ack.
  logic hold_req       = 1'b0;
  logic hold_ack       = 1'b0;

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Counts wider than the response field are clipped to its maximum.
  function automatic logic [pkrct_pkg::OutW-1:0] to_output_width(
      input logic [pkrct_pkg::CountWidth-1:0] c);
    longint unsigned v;
    longint unsigned out_max;
    v       = 64'(c);
    out_max = (64'd1 << pkrct_pkg::OutW) - 64'd1;
    return (v > out_max) ? {pkrct_pkg::OutW{1'b1}} : pkrct_pkg::OutW'(v);
  endfunction

  // Applies one accepted item to the local table and returns the response it causes.
  function automatic count_result_t apply_table_request(
      input pkrct_pkg::op_e op, input logic [pkrct_pkg::KeyW-1:0] ip);
    count_result_t r;
    int            idx;
    int            slot;
    r    = '0;
    idx  = -1;
    slot = -1;
    for (int i = 0; i < pkrct_pkg::TableDepth; i++) begin
      if (idx < 0 && slot_busy[i] && slot_key[i] == ip) begin
        idx = i;
      end
    end
    r.hit = (idx >= 0);
    case (op)
      pkrct_pkg::OP_ENQUEUE: begin
        if (idx >= 0) begin
          // A count already at its maximum stays there.
          if (slot_count[idx] != CountMax) begin
            slot_count[idx] = slot_count[idx] + 1'b1;
          end
          r.count = to_output_width(slot_count[idx]);
        end else begin
          // A new key claims the free entry with the lowest index.
          for (int i = 0; i < pkrct_pkg::TableDepth; i++) begin
            if (slot < 0 && !slot_busy[i]) begin
              slot = i;
            end
          end
          if (slot >= 0) begin
            slot_busy[slot]  = 1'b1;
            slot_key[slot]   = ip;
            slot_count[slot] = pkrct_pkg::CountWidth'(1);
            r.count          = pkrct_pkg::OutW'(1);
          end else begin
            r.full = 1'b1;
          end
        end
      end
      pkrct_pkg::OP_DEQUEUE: begin
        if (idx >= 0) begin
          if (slot_count[idx] <= 1) begin
            slot_count[idx] = '0;
            slot_busy[idx]  = 1'b0;
          end else begin
            slot_count[idx] = slot_count[idx] - 1'b1;
          end
          r.count = to_output_width(slot_count[idx]);
        end
      end
      pkrct_pkg::OP_QUERY: begin
        if (idx >= 0) begin
          r.count = to_output_width(slot_count[idx]);
        end
      end
      default: begin
        if (idx >= 0) begin
          slot_busy[idx] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------------

  // Offers one item, possibly after a random idle gap, and records its expected
  // response once it is accepted. Valid is left high on return so that a
  // following item can go out back to back.
  task automatic send_request(input pkrct_pkg::op_e op, input logic [pkrct_pkg::KeyW-1:0] ip);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= op;
    req_if.client_addr <= ip;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    expected_results.push_back(apply_table_request(op, ip));
  endtask

  // ------------------------------------------------------------------------
  // Response side
  // ------------------------------------------------------------------------

  // Ready is withdrawn at random, or for a whole stretch while a hold-off is running.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HoldOffCycles - 1;
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Every accepted response is compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("response with nothing outstanding: count %0h hit %0b full %0b",
                                  rsp_if.request_count, rsp_if.hit, rsp_if.table_full));
      end else begin
        oldest_result = expected_results.pop_front();
        if (rsp_if.request_count !== oldest_result.count) begin
          report_mismatch($sformatf("request_count %0h, expected %0h",
                                    rsp_if.request_count, oldest_result.count));
        end
        if (rsp_if.hit !== oldest_result.hit) begin
          report_mismatch($sformatf("hit %0b, expected %0b", rsp_if.hit, oldest_result.hit));
        end
        if (rsp_if.table_full !== oldest_result.full) begin
          report_mismatch($sformatf("table_full %0b, expected %0b",
                                    rsp_if.table_full, oldest_result.full));
        end
      end
    end
  end

  // The run is abandoned if neither channel moves an item for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Misses on an empty table, hits, increments, the dequeue that frees an entry,
  // remove with and without a hit, and the two extreme keys. The table is empty
  // again at the end.
  task automatic test_basic_ops();
    send_request(pkrct_pkg::OP_QUERY,   32'h0000_0000);
    send_request(pkrct_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_request(pkrct_pkg::OP_REMOVE,  32'h0000_0000);
    send_request(pkrct_pkg::OP_ENQUEUE, 32'h0000_0000);
    send_request(pkrct_pkg::OP_ENQUEUE, 32'h0000_0000);
    send_request(pkrct_pkg::OP_QUERY,   32'h0000_0000);
    send_request(pkrct_pkg::OP_ENQUEUE, 32'hFFFF_FFFF);
    send_request(pkrct_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_request(pkrct_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_request(pkrct_pkg::OP_QUERY,   32'h0000_0000);
    send_request(pkrct_pkg::OP_ENQUEUE, 32'h0000_0000);
    send_request(pkrct_pkg::OP_REMOVE,  32'hFFFF_FFFF);
    send_request(pkrct_pkg::OP_QUERY,   32'hFFFF_FFFF);
    send_request(pkrct_pkg::OP_REMOVE,  32'h0000_0000);
    send_request(pkrct_pkg::OP_DEQUEUE, 32'h0000_0000);
    send_request(pkrct_pkg::OP_ENQUEUE, 32'hA5A5_5A5A);
    send_request(pkrct_pkg::OP_DEQUEUE, 32'hA5A5_5A5A);
  endtask

  // Fills every entry, has one more new key refused, frees a middle entry so
  // that the next new key must land there, and then empties the table.
  task automatic test_full_table();
    logic [pkrct_pkg::KeyW-1:0] ip_base;
    ip_base = $urandom;
    for (int i = 0; i <= pkrct_pkg::TableDepth; i++) begin
      send_request(pkrct_pkg::OP_ENQUEUE, ip_base ^ pkrct_pkg::KeyW'(i));
    end
    send_request(pkrct_pkg::OP_REMOVE,
                 ip_base ^ pkrct_pkg::KeyW'(pkrct_pkg::TableDepth / 2));
    send_request(pkrct_pkg::OP_ENQUEUE,
                 ip_base ^ pkrct_pkg::KeyW'(pkrct_pkg::TableDepth + 1));
    send_request(pkrct_pkg::OP_QUERY,
                 ip_base ^ pkrct_pkg::KeyW'(pkrct_pkg::TableDepth + 1));
    send_request(pkrct_pkg::OP_ENQUEUE,
                 ip_base ^ pkrct_pkg::KeyW'(pkrct_pkg::TableDepth + 2));
    for (int i = 0; i <= pkrct_pkg::TableDepth + 2; i++) begin
      send_request(pkrct_pkg::OP_REMOVE, ip_base ^ pkrct_pkg::KeyW'(i));
    end
  endtask

  // Builds one count up over a long run of back-to-back enqueues, then reads it,
  // takes one away and removes the entry. Run without idling to keep it short.
  task automatic test_count_climb();
    logic [pkrct_pkg::KeyW-1:0] ip;
    ip             = $urandom;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (ClimbSteps) begin
      send_request(pkrct_pkg::OP_ENQUEUE, ip);
    end
    send_request(pkrct_pkg::OP_QUERY,   ip);
    send_request(pkrct_pkg::OP_DEQUEUE, ip);
    send_request(pkrct_pkg::OP_REMOVE,  ip);
  endtask

  // Enqueue-heavy mix over a pool of keys a little larger than the table, so
  // that hits, misses, fills and refusals all occur; a share of fully random
  // keys exercises every key bit and adds misses.
  task automatic run_random_phase(input int items, input int idle_pct, input int stall_pct);
    int                         pick;
    pkrct_pkg::op_e             op;
    logic [pkrct_pkg::KeyW-1:0] ip;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        op = pkrct_pkg::OP_ENQUEUE;
      end else if (pick < 65) begin
        op = pkrct_pkg::OP_DEQUEUE;
      end else if (pick < 85) begin
        op = pkrct_pkg::OP_QUERY;
      end else begin
        op = pkrct_pkg::OP_REMOVE;
      end
      if ($urandom_range(99) < 85) begin
        ip = key_pool[$urandom_range(KeyPoolSize - 1)];
      end else begin
        ip = $urandom;
      end
      send_request(op, ip);
    end
  endtask

  task automatic test_random_traffic();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KeyPoolSize; i++) begin
      key_pool[i] = $urandom;
    end
    run_random_phase(100, 0,  0);
    run_random_phase(100, 70, 0);
    run_random_phase(100, 0,  70);
    run_random_phase(100, 14, 14);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // result register fills and the block has to stop taking requests.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req      <= ~hold_req;
    run_random_phase(50, 0, 0);
  endtask

  // ------------------------------------------------------------------------
  // Sequence of the run
  // ------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < pkrct_pkg::TableDepth; i++) begin
      slot_busy[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_count[i] = '0;
    end
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= pkrct_pkg::OP_ENQUEUE;
    req_if.client_addr <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_full_table();
    test_count_climb();
    test_random_traffic();
    test_output_backpressure();

    // Drain: every response must arrive, and nothing further may follow.
    req_if.valid  <= 1'b0;
    recv_stall_pct = 0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
